// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

  // one accepted input beat
  typedef struct packed {
    logic [31:0] msg_word;
    logic        start_message;
    logic        end_message;
  } in_item_t;

  // one digest beat
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  localparam int BLOCK_WORDS = 16;
  localparam int BLOCK_BITS  = 32 * BLOCK_WORDS;

  // a complete block handed from the front to the back
  typedef struct packed {
    logic                  restart;  // reload initial hash before this block
    logic                  emit;     // send the digest after this block
    logic [BLOCK_BITS-1:0] data;     // word zero in the top bits
  } blk_t;

  localparam logic [0:7][31:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ----- rtl/sha256_block_hash.sv -----
// SHA-256 compression of an already padded message.
// Input: a beat is taken when start is high and busy is low; item carries one
// big-endian 32-bit word, sixteen words per 512-bit block. start_message on a
// beat reloads the initial hash and makes that word the first of a new block;
// end_message on the sixteenth word of a block requests the digest, on any
// other word it is ignored.
// Output: done is high for one cycle per digest word, eight beats in a row,
// word zero first, digest_last on the eighth. The receiver cannot stall.
// The sixteenth word writes its block into the queue; the core takes it from
// the queue head once idle, runs 64 rounds at one round per cycle, adds the
// working variables into the chaining value, then sends the digest beats.
// The compression core sets the rate, including the time spent on digest beats.
// A two-block queue between the word gatherer and the core lets a new block
// fill while the previous one is hashed; busy is high while the queue is full.
// Reset clears the queue and the word count and loads the initial hash.
module sha256_block_hash
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  logic take;
  logic push;
  blk_t push_blk;
  logic pop;
  blk_t head;
  logic not_empty;
  logic full;

  assign busy = full;
  assign take = start && !full;

  // word gathering
  sha256_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .push (push),
    .blk  (push_blk)
  );

  // block queue
  sha256_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_blk  (push_blk),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  // compression core
  sha256_back u_back (
    .clk       (clk),
    .rst       (rst),
    .blk       (head),
    .blk_valid (not_empty),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- rtl/sha256_front.sv -----
module sha256_front
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output logic     push,
  output blk_t     blk
);

  logic [3:0]            word_idx;
  logic                  restart_seen;
  logic [BLOCK_BITS-1:0] data;

  logic [3:0]            eff_idx;
  logic                  restart_eff;
  logic [BLOCK_BITS-1:0] data_next;

  // a start beat always becomes word zero of a fresh block
  assign eff_idx     = item.start_message ? 4'd0 : word_idx;
  assign restart_eff = item.start_message | restart_seen;
  assign data_next   = {data[BLOCK_BITS-33:0], item.msg_word};

  // block completes on the sixteenth beat
  assign push        = take && (eff_idx == 4'd15);
  assign blk.restart = restart_eff;
  assign blk.emit    = item.end_message;
  assign blk.data    = data_next;

  // word gathering
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx     <= 4'd0;
      restart_seen <= 1'b0;
    end else if (take) begin
      if (eff_idx == 4'd15) begin
        word_idx     <= 4'd0;
        restart_seen <= 1'b0;
      end else begin
        word_idx     <= eff_idx + 4'd1;
        restart_seen <= restart_eff;
      end
    end
  end

  // shift register, payload only
  always_ff @(posedge clk) begin
    if (take) begin
      data <= data_next;
    end
  end

endmodule

// ----- rtl/sha256_queue.sv -----
module sha256_queue
  import sha256_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  blk_t push_blk,
  input  logic pop,
  output blk_t head,
  output logic not_empty,
  output logic full
);

  blk_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_blk;
    end
  end

endmodule

// ----- rtl/sha256_back.sv -----
module sha256_back
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  blk_t      blk,
  input  logic      blk_valid,
  output logic      pop,
  output logic      done,
  output out_item_t result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic        emit;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] ch;
  logic [31:0] maj;

  assign pop = (state == ST_IDLE) && blk_valid;

  // one round and one schedule word per cycle
  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + bsig1(v[4]) + ch + ROUND_K[round] + w[0];
    t2    = bsig0(v[0]) + maj;
    w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  end

  // sequencer, chaining value and digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      round   <= 6'd0;
      out_idx <= 3'd0;
      emit    <= 1'b0;
      done    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_HASH[i];
      end
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (blk_valid) begin
            emit  <= blk.emit;
            round <= 6'd0;
            state <= ST_ROUND;
            if (blk.restart) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= INIT_HASH[i];
              end
            end
          end
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          out_idx <= 3'd0;
          state   <= emit ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          done    <= 1'b1;
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working variables, schedule window and output beat
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && blk_valid) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= blk.restart ? INIT_HASH[i] : chain[i];
      end
      for (int i = 0; i < 16; i++) begin
        w[i] <= blk.data[BLOCK_BITS - 1 - 32 * i -: 32];
      end
    end else if (state == ST_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end
    if (state == ST_EMIT) begin
      result.digest_word <= chain[out_idx];
      result.digest_last <= (out_idx == 3'd7);
    end
  end

endmodule

// ----- tb/sv/sha256_tb_pkg.sv -----
package sha256_tb_pkg;

  import sha256_pkg::in_item_t;
  import sha256_pkg::out_item_t;

  // sha-256 round constants and initial chaining value
  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  class sha256_scoreboard;
    logic [0:7][31:0] chain;
    logic [31:0]      words [16];
    logic [3:0]       idx;
    out_item_t        digest_q [$];
    int               errors;
    int               blocks;
    int               digests;
    int               checked;

    function new();
      chain   = SHA_IV;
      idx     = '0;
      errors  = 0;
      blocks  = 0;
      digests = 0;
      checked = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function logic [31:0] ror32(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function logic [31:0] ep0(input logic [31:0] v);
      return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
    endfunction

    function logic [31:0] ep1(input logic [31:0] v);
      return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
    endfunction

    function logic [31:0] sg0(input logic [31:0] v);
      return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
    endfunction

    function logic [31:0] sg1(input logic [31:0] v);
      return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    // schedule expansion, 64 rounds, then add into the chaining value
    function void compress_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int r = 0; r < 16; r++) sched[r] = words[r];
      for (int r = 16; r < 64; r++)
        sched[r] = sg1(sched[r-2]) + sched[r-7] + sg0(sched[r-15]) + sched[r-16];
      {a, b, c, d, e, f, g, h} = chain;
      for (int r = 0; r < 64; r++) begin
        t1 = h + ep1(e) + ((e & f) ^ (~e & g)) + SHA_K[r] + sched[r];
        t2 = ep0(a) + ((a & b) ^ (a & c) ^ (b & c));
        h = g;
        g = f;
        f = e;
        e = d + t1;
        d = c;
        c = b;
        b = a;
        a = t1 + t2;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
      chain[5] = chain[5] + f;
      chain[6] = chain[6] + g;
      chain[7] = chain[7] + h;
    endfunction

    // accepted input beat: update the hash state, queue digest words if due
    function void note_input(input in_item_t it);
      out_item_t d;
      if (it.start_message) begin
        chain = SHA_IV;
        idx   = '0;
      end
      words[idx] = it.msg_word;
      if (idx != 4'd15) begin
        idx = idx + 4'd1;
      end else begin
        idx = '0;
        compress_block();
        blocks++;
        // end flag only counts on the last word of a block
        if (it.end_message) begin
          for (int k = 0; k < 8; k++) begin
            d.digest_word = chain[k];
            d.digest_last = (k == 7);
            digest_q.push_back(d);
          end
          digests++;
        end
      end
    endfunction

    // accepted digest beat against the oldest expected word
    function void check_result(input out_item_t got);
      out_item_t want;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat: word %h last %b",
                 $time, got.digest_word, got.digest_last);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      checked++;
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word mismatch: expected %h actual %h",
                 $time, want.digest_word, got.digest_word);
        errors++;
      end
      if (got.digest_last !== want.digest_last) begin
        $display("%0t: digest_last mismatch: expected %b actual %b",
                 $time, want.digest_last, got.digest_last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::in_item_t;
  import sha256_pkg::out_item_t;
  import sha256_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 200;

  logic      clk;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  sha256_scoreboard sb = new();
  int words_sent = 0;
  int cycles     = 0;

  sha256_block_hash i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // every digest beat is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_word(input logic [31:0] w, input logic s, input logic e,
                           input int idle_pct);
    in_item_t it;
    it.msg_word      = w;
    it.start_message = s;
    it.end_message   = e;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    words_sent++;
  endtask

  // sender holds off until all digests are out and the core has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed messages, some open-ended chains, cut blocks and noise
  task automatic send_message(input int idle_pct);
    int kind;
    int nwords;
    logic s;
    logic e;
    kind = $urandom_range(9);
    if (kind <= 7) begin
      nwords = 16 * $urandom_range(1, 3);
      for (int i = 0; i < nwords; i++) begin
        s = (i == 0) && ($urandom_range(5) != 0);
        if (i == nwords - 1)
          e = (kind != 7);
        else
          e = (i % 16 != 15) && ($urandom_range(7) == 0);
        send_word(pick_word(), s, e, idle_pct);
      end
    end else if (kind == 8) begin
      nwords = $urandom_range(1, 15);
      for (int i = 0; i < nwords; i++)
        send_word(pick_word(), i == 0, $urandom_range(3) == 0, idle_pct);
    end else begin
      nwords = $urandom_range(1, 20);
      for (int i = 0; i < nwords; i++)
        send_word(pick_word(), $urandom_range(3) == 0, $urandom_range(1) == 1,
                  idle_pct);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: mostly all-ones words with stray end flags, then a restart that
    // drops the partial block and hashes the padded "abc" block
    send_word(32'hffff_ffff, 1'b0, 1'b0, 0);
    send_word(32'hffff_ffff, 1'b0, 1'b0, 0);
    send_word(32'hffff_ffff, 1'b0, 1'b1, 0);
    send_word(32'h0000_0000, 1'b0, 1'b0, 0);
    send_word(32'hffff_ffff, 1'b0, 1'b1, 0);
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:  send_word(32'h6162_6380, 1'b1, 1'b0, 0);
        15: send_word(32'h0000_0018, 1'b0, 1'b1, 0);
        default: send_word(32'h0000_0000, 1'b0, 1'b0, 0);
      endcase
    end
    drain();

    // random: light sender idling, then heavy, then none
    while (words_sent < 70) send_message(27);
    drain();
    while (words_sent < 120) send_message(76);
    drain();
    while (words_sent < 165) send_message(0);
    drain();

    $display("sent %0d words, %0d blocks compressed, %0d digests expected",
             words_sent, sb.blocks, sb.digests);
    $display("checked %0d digest words in %0d cycles", sb.checked, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_queue.sv
rtl/sha256_back.sv
rtl/sha256_block_hash.sv
tb/sv/sha256_tb_pkg.sv
tb/sv/tb_top.sv
